// ===== rtl/mctp_serial_frame_receiver_top_macros.svh =====
// Assertion helpers for the frame receiver; clocked on clk_i, quiet in reset.
`ifndef MCTP_SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define MCTP_SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define MSFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msfr: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define MSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msfr: next-cycle check failed");

`endif

// ===== rtl/msfr_pkg.sv =====
`default_nettype none
package msfr_pkg;

  localparam logic [7:0]  FlagByte      = 8'h7E;
  localparam logic [7:0]  EscByte       = 8'h7D;
  localparam logic [7:0]  EscMask       = 8'h20;
  localparam logic [7:0]  SerialVersion = 8'h01;
  localparam logic [15:0] FcsInit       = 16'hFFFF;
  localparam logic [15:0] FcsPoly       = 16'h8408;
  localparam logic [7:0]  MaxLengthRst  = 8'd74;

  // register indexes on the configuration port
  localparam logic RegMaxLength = 1'b0;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StHeader  = 3'd1,
    StData    = 3'd2,
    StEscape  = 3'd3,
    StTrailer = 3'd4,
    StError   = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    KindData     = 2'd0,
    KindGood     = 2'd1,
    KindBadFcs   = 2'd2,
    KindFrameErr = 2'd3
  } kind_e;

  // Fold one byte into the reflected CRC-16 CCITT.
  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FcsPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/msfr_byte_if.sv =====
`default_nettype none
interface msfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/msfr_result_if.sv =====
`default_nettype none
interface msfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
  logic [7:0] frame_length;

  modport source (output valid, output kind, output data, output last,
                  output frame_length, input ready);
  modport sink (input valid, input kind, input data, input last,
                input frame_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/mctp_serial_frame_receiver_top.sv =====
`default_nettype none
// Channel   Dir  Payload                              Handshake
// rx_i      in   rx_byte[7:0]                         valid/ready
// res_o     out  kind[1:0] data[7:0] last frame_length valid/ready
// apb       in   max_length at byte address 0         psel/penable/pwrite, pready
//
// One raw byte is taken per cycle; the byte-wide CRC update and the parser
// step finish in that cycle, and any result lands in the output register.
// A word waits in the output register while the next byte is already taken,
// unless the sink stalls: then rx_i.ready drops until the word leaves.
// Reset (rst_ni low, asynchronous) sets the parser idle, empties the output
// register and loads max_length with 74.
`include "mctp_serial_frame_receiver_top_macros.svh"
module mctp_serial_frame_receiver_top
  import msfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  msfr_byte_if.sink        rx_i,
  msfr_result_if.source    res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        max_len_sel;
  logic [7:0]  max_len_q;
  state_e      state_q, state_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] fcs_q, fcs_d;
  logic [15:0] rx_fcs_q, rx_fcs_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic [7:0]  flen_q;
  logic        emit;

  logic        accept;
  logic [7:0]  c;
  logic [7:0]  byte_w;
  logic [7:0]  pos_inc;
  logic [15:0] crc_in;
  logic [7:0]  crc_byte;
  logic [15:0] crc_out;
  logic        cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign max_len_sel = (paddr[2] == RegMaxLength);
  assign prdata = max_len_sel ? {24'h0, max_len_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLengthRst;
    end else if (cfg_wr && max_len_sel) begin
      max_len_q <= pwdata[7:0];
    end
  end

  // take a byte whenever the output register is free or emptying
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;

  // share one CRC update between the version byte and the rest
  assign byte_w   = (state_q == StEscape) ? (c | EscMask) : c;
  assign crc_in   = (state_q == StHeader && pos_q == 8'd1) ? FcsInit : fcs_q;
  assign crc_byte = (state_q == StHeader) ? c : byte_w;
  assign crc_out  = fcs_update(crc_in, crc_byte);
  assign pos_inc  = pos_q + 8'd1;

  // parser step
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    len_d    = len_q;
    fcs_d    = fcs_q;
    rx_fcs_d = rx_fcs_q;
    emit     = 1'b0;
    kind_d   = KindData;
    data_d   = 8'h00;
    last_d   = 1'b0;
    if (accept) begin
      case (state_q)
        StHeader: begin
          if (pos_q == 8'd1) begin
            if (c == FlagByte) begin
              state_d = StHeader;
            end else if (c != SerialVersion) begin
              state_d = StError;
              pos_d   = 8'd0;
              emit    = 1'b1;
              kind_d  = KindFrameErr;
            end else begin
              fcs_d = crc_out;
              pos_d = 8'd2;
            end
          end else if (c == 8'd0 || c > max_len_q) begin
            state_d = StError;
            pos_d   = 8'd0;
            emit    = 1'b1;
            kind_d  = KindFrameErr;
          end else begin
            len_d   = c;
            fcs_d   = crc_out;
            pos_d   = 8'd0;
            state_d = StData;
          end
        end
        StData, StEscape: begin
          if (state_q == StData && c == EscByte) begin
            state_d = StEscape;
          end else begin
            fcs_d  = crc_out;
            emit   = 1'b1;
            kind_d = KindData;
            data_d = byte_w;
            if (pos_inc >= len_q) begin
              pos_d   = 8'd0;
              state_d = StTrailer;
              last_d  = 1'b1;
            end else begin
              pos_d   = pos_inc;
              state_d = StData;
            end
          end
        end
        StTrailer: begin
          if (pos_q == 8'd0) begin
            rx_fcs_d = {c, 8'h00};
            pos_d    = 8'd1;
          end else if (pos_q == 8'd1) begin
            rx_fcs_d = {rx_fcs_q[15:8], c};
            pos_d    = 8'd2;
          end else if (c != FlagByte) begin
            state_d = StError;
            pos_d   = 8'd0;
            emit    = 1'b1;
            kind_d  = KindFrameErr;
          end else begin
            state_d = StIdle;
            pos_d   = 8'd0;
            emit    = 1'b1;
            kind_d  = (rx_fcs_q == fcs_q) ? KindGood : KindBadFcs;
          end
        end
        StError: begin
          if (c == FlagByte) begin
            state_d  = StHeader;
            pos_d    = 8'd1;
            len_d    = 8'd0;
            fcs_d    = 16'h0000;
            rx_fcs_d = 16'h0000;
          end
        end
        default: begin
          if (c != FlagByte) begin
            len_d   = 8'd0;
            state_d = StError;
            pos_d   = 8'd0;
            emit    = 1'b1;
            kind_d  = KindFrameErr;
          end else begin
            state_d  = StHeader;
            pos_d    = 8'd1;
            len_d    = 8'd0;
            fcs_d    = 16'h0000;
            rx_fcs_d = 16'h0000;
          end
        end
      endcase
    end
  end

  // hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pos_q    <= 8'd0;
      len_q    <= 8'd0;
      fcs_q    <= 16'h0000;
      rx_fcs_q <= 16'h0000;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      fcs_q    <= fcs_d;
      rx_fcs_q <= rx_fcs_d;
    end
  end

  // output register: load on a new word, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      last_q <= last_d;
      flen_q <= len_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.data         = data_q;
  assign res_o.last         = last_q;
  assign res_o.frame_length = flen_q;

  // checks
  `MSFR_ASSERT_NOW(a_status_clean, out_valid_q && kind_q != KindData, data_q == 8'h00 && !last_q)
  `MSFR_ASSERT_NOW(a_last_to_trailer, out_valid_q && kind_q == KindData && last_q,
                   state_q == StTrailer && pos_q == 8'd0)
  `MSFR_ASSERT_NOW(a_err_state, out_valid_q && kind_q == KindFrameErr, state_q == StError)
  `MSFR_ASSERT_NOW(a_close_idle, out_valid_q && (kind_q == KindGood || kind_q == KindBadFcs),
                   state_q == StIdle)
  `MSFR_ASSERT_NOW(a_stall_blocks, out_valid_q && !res_o.ready, !rx_i.ready)

endmodule
`default_nettype wire
